@@ sv/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the semantic cost stamp block
// Grid geometry, rule packing, item types and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none
package scs_pkg;

  localparam int GRID_WIDTH       = 256;
  localparam int GRID_HEIGHT      = 256;
  localparam int MAX_RADIUS_CELLS = 32;
  localparam int NUM_CLASSES      = 4;

  localparam int GRID_CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int RULE_W     = 23;
  localparam int NUM_RULES  = 4;
  localparam int CFG_IDX_W  = 2;

  localparam int R_W     = 14;                    // radius, Q6.8
  localparam int RC_W    = 6;                     // integer radius
  localparam int OFS_W   = RC_W + 1;              // signed offset
  localparam int COORD_W = 11;                    // signed cell coordinate
  localparam int SQ_W    = 2 * RC_W + 1;          // dx*dx + dy*dy
  localparam int V_W     = SQ_W + 16 + 1;         // radicand, even width
  localparam int ROOT_W  = V_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int NUM_W   = 8 + R_W;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  localparam logic [R_W-1:0] R_CAP = R_W'(MAX_RADIUS_CELLS << 8);

  typedef enum logic [1:0] {
    FUNC_STAMP = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] class_index;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [8:0] win_min_x;
    logic [8:0] win_min_y;
    logic [8:0] win_max_x;
    logic [8:0] win_max_y;
    logic [7:0] write_cost;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_cost;
    logic       skipped;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic item_read;
    logic rd_capture;
    logic item_write;
    logic set_skip;
    logic stamp_init;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic cell_read;
    logic cell_write;
    logic adv;
    logic out_load;
  } scs_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic clear_done;
    logic rule_ok;
    logic cell_ok;
    logic last_cell;
    logic sqrt_last;
    logic d_gt_r;
    logic div_last;
    logic out_free;
  } scs_stat_t;

endpackage
`default_nettype wire

@@ sv/scs_if.sv @@
// ----------------------------------------------------------------------------
// scs_in_if / scs_out_if: valid/ready channels of the semantic cost stamp
// One item moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none
interface scs_in_if;
  logic              valid;
  logic              ready;
  scs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface scs_out_if;
  logic               valid;
  logic               ready;
  scs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/semantic_cost_stamp.sv @@
// ----------------------------------------------------------------------------
// semantic_cost_stamp: 256 x 256 cost grid with per-class linear cost cones
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// After reset the block clears the grid one cell a cycle, 65536 cells in
// all, and takes no item until then; configuration writes are taken at any
// time. A write item passes the dispatch state and a read item the
// dispatch and read-wait states before the result goes to the output
// register. A stamp walks the (2*rc+1)^2 square: a cell that falls outside
// the window or grid is passed over, a cell beyond the radius leaves after
// the square root unit, and a cell that is updated also passes the divider
// and a read-modify-write on the one memory port. One item is worked on at a
// time, and the next is taken once the result has moved to the output
// register.
`default_nettype none
module semantic_cost_stamp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  scs_in_if.sink                             in_item,
  scs_out_if.source                          out_item,
  input  wire logic                          cfg_we,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scs_pkg::RULE_W-1:0]    cfg_wdata
);
  import scs_pkg::*;

  scs_cmd_t  cmd;
  scs_stat_t stat;

  scs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_item.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_data  (out_item.data)
  );

endmodule
`default_nettype wire

@@ sv/scs_ctrl.sv @@
// ----------------------------------------------------------------------------
// scs_ctrl: sequencer of the semantic cost stamp
// Clears the grid after reset, then runs each item through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module scs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire scs_pkg::scs_stat_t stat,
  output scs_pkg::scs_cmd_t      cmd
);
  import scs_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_DISPATCH = 10'b0000000100,
    S_RD_WAIT  = 10'b0000001000,
    S_CELL     = 10'b0000010000,
    S_SQRT     = 10'b0000100000,
    S_CMP      = 10'b0001000000,
    S_DIV      = 10'b0010000000,
    S_RMW_RD   = 10'b0100000000,
    S_RMW_WR   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   resp_r, resp_nxt;   // result pending towards the output register

  assign in_ready = (state_r == S_IDLE) && !resp_r;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    if (resp_r && stat.out_free) begin
      cmd.out_load = 1'b1;
      resp_nxt     = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          FUNC_READ: begin
            cmd.item_read = 1'b1;
            state_nxt     = S_RD_WAIT;
          end
          FUNC_WRITE: begin
            cmd.item_write = 1'b1;
            resp_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end
          FUNC_STAMP: begin
            if (stat.rule_ok) begin
              cmd.stamp_init = 1'b1;
              state_nxt      = S_CELL;
            end else begin
              cmd.set_skip = 1'b1;
              resp_nxt     = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          default: begin
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        resp_nxt       = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_CELL: begin
        if (stat.cell_ok) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end else begin
          cmd.adv = 1'b1;
          if (stat.last_cell) begin
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.d_gt_r) begin
          cmd.adv = 1'b1;
          if (stat.last_cell) begin
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CELL;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_RMW_RD;
      end
      S_RMW_RD: begin
        cmd.cell_read = 1'b1;
        state_nxt     = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.cell_write = 1'b1;
        cmd.adv        = 1'b1;
        if (stat.last_cell) begin
          resp_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CELL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      resp_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

  a_out_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> resp_r)
    else $error("result loaded with no item pending");

  a_rmw_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cell_write |-> $past(cmd.cell_read))
    else $error("cell write without preceding read");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> state_r == S_CLEAR)
    else $error("grid clear not started after reset");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |=> !in_ready)
    else $error("second item accepted while busy");

endmodule
`default_nettype wire

@@ sv/scs_datapath.sv @@
// ----------------------------------------------------------------------------
// scs_datapath: grid memory, rule registers and stamp arithmetic
// Holds the cost grid, walks the stamp square and runs the square root
// and divider units one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module scs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [scs_pkg::RULE_W-1:0]    cfg_wdata,
  input  wire scs_pkg::in_item_t             in_data,
  input  wire scs_pkg::scs_cmd_t             cmd,
  output scs_pkg::scs_stat_t                 stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output scs_pkg::out_item_t                 out_data
);
  import scs_pkg::*;

  logic [RULE_W-1:0] rule_r [NUM_RULES];
  in_item_t          item_r;
  logic [ADDR_W:0]   clr_cnt_r;
  logic [7:0]        grid_mem [GRID_CELLS];
  logic [7:0]        mem_q_r;
  logic [7:0]        rd_r;
  logic              skip_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [7:0]         peak_r;
  logic [R_W-1:0]     r_r;
  logic [RC_W-1:0]    rc_r;
  logic signed [OFS_W-1:0] dx_r, dy_r;
  logic [V_W-1:0]     v_r;
  logic [REM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [SQ_CNT_W-1:0] scnt_r;
  logic [NUM_W-1:0]   drem_r, dvs_r;
  logic [7:0]         q_r;
  logic [2:0]         dcnt_r;

  // Rule fields of the addressed class.
  logic [RULE_W-1:0] rule_sel;
  logic [R_W-1:0]    r_raw, r_sat;
  logic              cls_ok;
  assign rule_sel = rule_r[item_r.class_index];
  assign r_raw    = rule_sel[22:9];
  assign r_sat    = (r_raw > R_CAP) ? R_CAP : r_raw;
  assign cls_ok   = {1'b0, item_r.class_index} < 3'(NUM_CLASSES);

  // Current cell of the walk.
  logic signed [COORD_W-1:0] cx, cy;
  logic [ADDR_W-1:0] cell_addr, item_addr;
  logic item_in_grid, cell_ok;
  assign cx = $signed({3'b0, item_r.cell_x}) + COORD_W'(dx_r);
  assign cy = $signed({3'b0, item_r.cell_y}) + COORD_W'(dy_r);
  assign cell_ok = (cx >= $signed({2'b0, item_r.win_min_x})) &&
                   (cx <  $signed({2'b0, item_r.win_max_x})) &&
                   (cy >= $signed({2'b0, item_r.win_min_y})) &&
                   (cy <  $signed({2'b0, item_r.win_max_y})) &&
                   (cx >= 0) && (cx < COORD_W'(GRID_WIDTH)) &&
                   (cy >= 0) && (cy < COORD_W'(GRID_HEIGHT));
  assign cell_addr = ADDR_W'(32'(cy) * GRID_WIDTH + 32'(cx));
  assign item_in_grid = ({1'b0, item_r.cell_x} < 9'(GRID_WIDTH)) &&
                        ({1'b0, item_r.cell_y} < 9'(GRID_HEIGHT));
  assign item_addr = ADDR_W'(32'(item_r.cell_y) * GRID_WIDTH + 32'(item_r.cell_x));

  logic last_cell;
  assign last_cell = (dx_r == $signed({1'b0, rc_r})) && (dy_r == $signed({1'b0, rc_r}));

  // Square of the offset, left as the radicand of the distance.
  logic signed [SQ_W-1:0] dx_w, dy_w;
  logic [SQ_W-1:0] sq;
  assign dx_w = SQ_W'(dx_r);
  assign dy_w = SQ_W'(dy_r);
  assign sq   = SQ_W'(dx_w * dx_w) + SQ_W'(dy_w * dy_w);

  // One root bit per cycle.
  logic [REM_W-1:0] srem_sh, strial;
  assign srem_sh = {srem_r[REM_W-3:0], v_r[V_W-1 -: 2]};
  assign strial  = {root_r, 2'b01};

  logic [NUM_W-1:0] prod;
  assign prod = NUM_W'(peak_r) * NUM_W'(r_r - R_W'(root_r));

  logic [7:0] add_val;
  assign add_val = (r_r == '0) ? peak_r : q_r;

  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wd;

  always_comb begin
    mem_addr = cell_addr;
    mem_we   = 1'b0;
    mem_wd   = add_val;
    if (cmd.clr_step) begin
      mem_addr = clr_cnt_r[ADDR_W-1:0];
      mem_we   = 1'b1;
      mem_wd   = '0;
    end else if (cmd.item_write || cmd.item_read) begin
      mem_addr = item_addr;
      mem_we   = cmd.item_write && item_in_grid;
      mem_wd   = item_r.write_cost;
    end else if (cmd.cell_write) begin
      mem_we = add_val > mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_addr] <= mem_wd;
    mem_q_r <= grid_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RULES; i++) rule_r[i] <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) rule_r[cfg_index] <= cfg_wdata;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
      rd_r   <= '0;
      skip_r <= 1'b0;
    end
    if (cmd.set_skip) skip_r <= 1'b1;
    if (cmd.rd_capture) rd_r <= item_in_grid ? mem_q_r : 8'd0;
    if (cmd.out_load) begin
      out_r.read_cost <= rd_r;
      out_r.skipped   <= skip_r;
    end
    if (cmd.stamp_init) begin
      peak_r <= rule_sel[8:1];
      r_r    <= r_sat;
      rc_r   <= r_sat[R_W-1:8];
      dx_r   <= -$signed({1'b0, r_sat[R_W-1:8]});
      dy_r   <= -$signed({1'b0, r_sat[R_W-1:8]});
    end
    if (cmd.adv) begin
      if (dx_r == $signed({1'b0, rc_r})) begin
        dx_r <= -$signed({1'b0, rc_r});
        dy_r <= dy_r + 1'b1;
      end else begin
        dx_r <= dx_r + 1'b1;
      end
    end
    if (cmd.sqrt_start) begin
      v_r    <= {1'b0, sq, 16'b0};
      srem_r <= '0;
      root_r <= '0;
      scnt_r <= SQ_CNT_W'(ROOT_W - 1);
    end
    if (cmd.sqrt_step) begin
      v_r    <= v_r << 2;
      scnt_r <= scnt_r - 1'b1;
      if (srem_sh >= strial) begin
        srem_r <= srem_sh - strial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        srem_r <= srem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.div_start) begin
      drem_r <= prod;
      dvs_r  <= NUM_W'({r_r, 7'b0});
      q_r    <= '0;
      dcnt_r <= 3'd7;
    end
    if (cmd.div_step) begin
      dvs_r  <= dvs_r >> 1;
      dcnt_r <= dcnt_r - 1'b1;
      if (drem_r >= dvs_r) begin
        drem_r <= drem_r - dvs_r;
        q_r    <= {q_r[6:0], 1'b1};
      end else begin
        q_r    <= {q_r[6:0], 1'b0};
      end
    end
  end

  assign stat.func       = item_r.func;
  assign stat.clear_done = clr_cnt_r == (ADDR_W+1)'(GRID_CELLS - 1);
  assign stat.rule_ok    = cls_ok && rule_sel[0];
  assign stat.cell_ok    = cell_ok;
  assign stat.last_cell  = last_cell;
  assign stat.sqrt_last  = scnt_r == '0;
  assign stat.d_gt_r     = ROOT_W'(root_r) > ROOT_W'(r_r);
  assign stat.div_last   = dcnt_r == '0;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
